@@ hdl/alfg_pkg.sv @@
// Shared types and constants of the linear fade gain block.
`default_nettype none

package alfg_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int GAIN_BITS = 16;
   localparam int GAIN_FRAC = 14;
   localparam int TIME_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int COUNT_BITS = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int DIV_CNT_BITS = $clog2(FRAC_BITS);
   localparam int SEQ_CNT_BITS = $clog2(FRAC_BITS + 1);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_START = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_END = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FADE_START = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FADE_END = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_COUNT = 3'd4;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          first_of_block;
      logic [TIME_BITS-1:0]          block_time;
      logic                          last_of_block;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic [GAIN_BITS-1:0]          gain_used;
      logic                          last_out;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

@@ hdl/alfg_div.sv @@
// Bit-serial restoring divider producing the Q0.16 fade fraction.
`default_nettype none

module alfg_div (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   input  wire  [alfg_pkg::TIME_BITS-1:0]       dividend,
   input  wire  [alfg_pkg::TIME_BITS-1:0]       divisor,
   output alfg_pkg::div_status_type             status,
   output logic [alfg_pkg::FRAC_BITS-1:0]       quotient
);
   import alfg_pkg::*;

   logic [TIME_BITS-1:0]    rem_ff, rem_in;
   logic [TIME_BITS-1:0]    den_ff;
   logic [FRAC_BITS-1:0]    quo_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic                    busy_ff;
   logic                    done_ff;
   logic [TIME_BITS:0]      shifted;
   logic [TIME_BITS:0]      trial;
   logic                    fits;

   // The dividend is always below the divisor, so the remainder fits in TIME_BITS.
   always_comb begin
      shifted = {rem_ff, 1'b0};
      trial   = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = fits ? trial[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_BITS'(FRAC_BITS - 1);
            rem_ff  <= dividend;
            den_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[FRAC_BITS-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

@@ hdl/audio_linear_fade_gain_top.sv @@
// Top level of the linear fade gain: frame timing, serial mix and scale, result register.
// Usage:
//   Samples arrive interleaved on the req_ channel, one per transaction. A transaction
//   with first_of_block set loads the frame time from block_time and restarts the channel
//   position; frame time advances each channel_count samples, clamped to 1..MAX_CHANNELS.
//   For each sample the block forms the fade fraction, mixes gain_start and gain_end,
//   scales the sample and presents sample_out, gain_used and last_out on the rsp_ channel.
//   Registers are written through csr_we, csr_index and csr_wdata; the user must do so
//   only while the block is idle, which the block itself does not enforce.
// Processing:
//   The fraction comes from a bit-serial divider, the gain mix and the sample product
//   from shift-and-add loops; outside the ramp the divider is skipped.
//   One sample is processed at a time.
// Reset and stalls:
//   Reset clears the frame time, the channel position, the result valid flag and the
//   registers to their defaults. A finished result waits in the output register while a
//   new sample is accepted; if the receiver still stalls when the next result is ready,
//   the block holds that result internally and takes no new sample until it is delivered.
`default_nettype none

module audio_linear_fade_gain_top #(
   parameter int MAX_CHANNELS = 8
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  alfg_pkg::req_type                       req_payload,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output alfg_pkg::rsp_type                       rsp_payload,
   input  wire                                     csr_we,
   input  wire  [alfg_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire  [alfg_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import alfg_pkg::*;

   localparam int CPOS_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CH_BITS = 8;
   localparam int ACC_BITS = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int R_BITS = ACC_BITS - GAIN_FRAC;
   localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [ACC_BITS-1:0] MIX_ROUND = ACC_BITS'(1) << (FRAC_BITS - 1);
   localparam logic [ACC_BITS-1:0] PROD_ROUND = ACC_BITS'(1) << (GAIN_FRAC - 1);
   localparam logic signed [R_BITS-1:0] R_MAX = R_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [R_BITS-1:0] R_MIN = -R_MAX - R_BITS'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FRAC,
      ST_DIV,
      ST_MIX,
      ST_MUL,
      ST_DONE
   } state_type;

   // Configuration registers.
   logic [GAIN_BITS-1:0]  gain_start_ff;
   logic [GAIN_BITS-1:0]  gain_end_ff;
   logic [TIME_BITS-1:0]  fade_start_ff;
   logic [TIME_BITS-1:0]  fade_end_ff;
   logic [COUNT_BITS-1:0] channel_count_ff;

   state_type                 state_ff;
   logic [TIME_BITS-1:0]      frame_time_ff;
   logic [CPOS_BITS-1:0]      pos_ff;
   logic [TIME_BITS-1:0]      now_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                      last_ff;
   logic [FRAC_BITS:0]        t_sr_ff;
   logic [FRAC_BITS:0]        u_sr_ff;
   logic [GAIN_BITS-1:0]      g_sr_ff;
   logic [GAIN_BITS-1:0]      gain_ff;
   logic [ACC_BITS-1:0]       acc_ff;
   logic [SEQ_CNT_BITS-1:0]   cnt_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_payload_ff;

   logic [TIME_BITS-1:0]      now_in;
   logic [CH_BITS-1:0]        chans;
   logic [CH_BITS-1:0]        pos_sum;
   logic [CPOS_BITS-1:0]      pos_base;
   logic                      frame_wrap;
   logic                      below_start;
   logic                      past_end;
   logic                      div_start;
   logic [TIME_BITS-1:0]      div_dividend;
   logic [TIME_BITS-1:0]      div_divisor;
   div_status_type            div_status;
   logic [FRAC_BITS-1:0]      div_quotient;
   logic [FRAC_BITS:0]        t_div;
   logic [ACC_BITS-1:0]       mix_in;
   logic [ACC_BITS-1:0]       mul_in;
   logic [ACC_BITS-1:0]       prod_sum;
   logic signed [R_BITS-1:0]  scaled;
   logic signed [SAMPLE_BITS-1:0] sat_in;
   logic                      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_start_ff    <= '0;
         gain_end_ff      <= '0;
         fade_start_ff    <= '0;
         fade_end_ff      <= '0;
         channel_count_ff <= COUNT_BITS'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAIN_START:    gain_start_ff    <= csr_wdata[GAIN_BITS-1:0];
            CSR_GAIN_END:      gain_end_ff      <= csr_wdata[GAIN_BITS-1:0];
            CSR_FADE_START:    fade_start_ff    <= csr_wdata[TIME_BITS-1:0];
            CSR_FADE_END:      fade_end_ff      <= csr_wdata[TIME_BITS-1:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Frame bookkeeping is settled at acceptance, using the channel count in force then.
   always_comb begin
      if (channel_count_ff == '0) begin
         chans = CH_BITS'(1);
      end else if (CH_BITS'(channel_count_ff) > CH_BITS'(MAX_CHANNELS)) begin
         chans = CH_BITS'(MAX_CHANNELS);
      end else begin
         chans = CH_BITS'(channel_count_ff);
      end
      now_in     = req_payload.first_of_block ? req_payload.block_time : frame_time_ff;
      pos_base   = req_payload.first_of_block ? '0 : pos_ff;
      pos_sum    = CH_BITS'(pos_base) + CH_BITS'(1);
      frame_wrap = pos_sum >= chans;
   end

   always_comb begin
      below_start  = now_ff < fade_start_ff;
      past_end     = now_ff >= fade_end_ff;
      div_start    = (state_ff == ST_FRAC) && !below_start && !past_end;
      div_dividend = now_ff - fade_start_ff;
      div_divisor  = fade_end_ff - fade_start_ff;
      t_div        = {1'b0, div_quotient};
   end

   alfg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // One bit of t and of one-minus-t per cycle for the mix, one gain bit per cycle for
   // the product, both most significant bit first.
   always_comb begin
      mix_in = {acc_ff[ACC_BITS-2:0], 1'b0}
             + (t_sr_ff[FRAC_BITS] ? ACC_BITS'(gain_end_ff) : '0)
             + (u_sr_ff[FRAC_BITS] ? ACC_BITS'(gain_start_ff) : '0);
      mul_in = {acc_ff[ACC_BITS-2:0], 1'b0}
             + (g_sr_ff[GAIN_BITS-1]
                ? {{(ACC_BITS-SAMPLE_BITS){sample_ff[SAMPLE_BITS-1]}}, sample_ff} : '0);
      prod_sum = acc_ff + PROD_ROUND;
      scaled   = $signed(prod_sum[ACC_BITS-1:GAIN_FRAC]);
      if (scaled > R_MAX) begin
         sat_in = R_MAX[SAMPLE_BITS-1:0];
      end else if (scaled < R_MIN) begin
         sat_in = R_MIN[SAMPLE_BITS-1:0];
      end else begin
         sat_in = scaled[SAMPLE_BITS-1:0];
      end
   end

   // Rounds the mix accumulator and keeps bits above the fraction; the sum stays below 2^32.
   function automatic logic [GAIN_BITS-1:0] mix_in_gain(input logic [ACC_BITS-1:0] acc);
      logic [ACC_BITS-1:0] rounded;
      rounded = acc + MIX_ROUND;
      return rounded[FRAC_BITS+GAIN_BITS-1:FRAC_BITS];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         frame_time_ff <= '0;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  now_ff        <= now_in;
                  sample_ff     <= req_payload.sample_in;
                  last_ff       <= req_payload.last_of_block;
                  frame_time_ff <= frame_wrap ? now_in + TIME_BITS'(1) : now_in;
                  pos_ff        <= frame_wrap ? '0 : pos_sum[CPOS_BITS-1:0];
                  state_ff      <= ST_FRAC;
               end
            end
            ST_FRAC: begin
               acc_ff <= '0;
               cnt_ff <= SEQ_CNT_BITS'(FRAC_BITS);
               if (below_start) begin
                  t_sr_ff  <= '0;
                  u_sr_ff  <= T_ONE;
                  state_ff <= ST_MIX;
               end else if (past_end) begin
                  t_sr_ff  <= T_ONE;
                  u_sr_ff  <= '0;
                  state_ff <= ST_MIX;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_status.done) begin
                  t_sr_ff  <= t_div;
                  u_sr_ff  <= T_ONE - t_div;
                  state_ff <= ST_MIX;
               end
            end
            ST_MIX: begin
               t_sr_ff <= {t_sr_ff[FRAC_BITS-1:0], 1'b0};
               u_sr_ff <= {u_sr_ff[FRAC_BITS-1:0], 1'b0};
               if (cnt_ff == '0) begin
                  // The mixed gain is rounded and its integer part taken before the product.
                  gain_ff  <= mix_in_gain(mix_in);
                  g_sr_ff  <= mix_in_gain(mix_in);
                  acc_ff   <= '0;
                  cnt_ff   <= SEQ_CNT_BITS'(GAIN_BITS - 1);
                  state_ff <= ST_MUL;
               end else begin
                  acc_ff <= mix_in;
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_MUL: begin
               acc_ff  <= mul_in;
               g_sr_ff <= {g_sr_ff[GAIN_BITS-2:0], 1'b0};
               cnt_ff  <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_payload_ff.sample_out <= sat_in;
                  rsp_payload_ff.gain_used  <= gain_ff;
                  rsp_payload_ff.last_out   <= last_ff;
                  state_ff                  <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("input taken while a transaction is in progress");

   a_div_busy_state: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> (state_ff == ST_DIV))
      else $error("divider running outside the divide state");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the done state");

   a_gain_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX) && (cnt_ff == '0) |=> gain_ff == $past(mix_in_gain(mix_in)))
      else $error("mixed gain not captured at the end of the mix");
`endif

endmodule

`default_nettype wire

@@ tb/sv/audio_linear_fade_gain_checker.sv @@
// Checker for the linear fade gain: mirrors the registers, predicts each result and compares.
`default_nettype none

module audio_linear_fade_gain_checker #(
   parameter int MAX_CHANNELS = 8
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   input  wire                                  req_ready,
   input  alfg_pkg::req_type                    req_payload,
   input  wire                                  rsp_valid,
   input  wire                                  rsp_ready,
   input  alfg_pkg::rsp_type                    rsp_payload,
   input  wire                                  csr_we,
   input  wire  [alfg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire  [alfg_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output int                                   mismatch_count,
   output int                                   outstanding
);

   import alfg_pkg::*;

   logic [15:0] cfg_gain_start = '0;
   logic [15:0] cfg_gain_end = '0;
   logic [31:0] cfg_ramp_start = '0;
   logic [31:0] cfg_ramp_end = '0;
   logic [3:0]  cfg_channels = 4'd1;

   logic [31:0] frame_time = '0;
   int          channel_pos = 0;
   int          fail_total = 0;

   rsp_type expected_samples[$];

   // Ramp position as Q1.16; one is 65536, so the result needs 17 bits.
   function automatic logic [16:0] fade_fraction(input logic [31:0] now);
      logic [47:0] num;
      logic [31:0] den;
      if (now < cfg_ramp_start)
         return 17'd0;
      if (now >= cfg_ramp_end)
         return 17'h10000;
      num = {now - cfg_ramp_start, 16'h0000};
      den = cfg_ramp_end - cfg_ramp_start;
      return 17'(num / 48'(den));
   endfunction

   function automatic logic [15:0] blend_gain(input logic [16:0] t);
      logic [49:0] acc;
      acc = 50'(cfg_gain_start) * 50'(17'h10000 - t) + 50'(cfg_gain_end) * 50'(t) + 50'd32768;
      return acc[31:16];
   endfunction

   // Rounds half up by flooring after adding half an LSB, then saturates.
   function automatic logic [15:0] scaled_sample(input logic signed [15:0] s,
                                                 input logic [15:0] g);
      longint prod;
      prod = longint'(s) * longint'(g) + 64'sd8192;
      prod = prod >>> GAIN_FRAC;
      if (prod > 64'sd32767)
         return 16'h7FFF;
      if (prod < -64'sd32768)
         return 16'h8000;
      return 16'(prod);
   endfunction

   task automatic note_failure(input string msg);
      fail_total++;
      $display("checker: %s", msg);
   endtask

   always @(posedge clock) begin
      rsp_type     want;
      logic [15:0] gain;
      int          chans;
      if (reset) begin
         cfg_gain_start = '0;
         cfg_gain_end = '0;
         cfg_ramp_start = '0;
         cfg_ramp_end = '0;
         cfg_channels = 4'd1;
         frame_time = '0;
         channel_pos = 0;
         expected_samples.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GAIN_START: cfg_gain_start = csr_wdata[15:0];
               CSR_GAIN_END: cfg_gain_end = csr_wdata[15:0];
               CSR_FADE_START: cfg_ramp_start = csr_wdata;
               CSR_FADE_END: cfg_ramp_end = csr_wdata;
               CSR_CHANNEL_COUNT: cfg_channels = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_payload.first_of_block) begin
               frame_time = req_payload.block_time;
               channel_pos = 0;
            end
            gain = blend_gain(fade_fraction(frame_time));
            want.sample_out = scaled_sample(req_payload.sample_in, gain);
            want.gain_used = gain;
            want.last_out = req_payload.last_of_block;
            expected_samples.push_back(want);
            chans = int'(cfg_channels);
            if (chans == 0)
               chans = 1;
            if (chans > MAX_CHANNELS)
               chans = MAX_CHANNELS;
            channel_pos++;
            if (channel_pos >= chans) begin
               channel_pos = 0;
               frame_time = frame_time + 32'd1;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               note_failure($sformatf("result with no sample outstanding, sample_out %0d",
                                      $signed(rsp_payload.sample_out)));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_payload.sample_out !== want.sample_out)
                  note_failure($sformatf("sample_out %0d, expected %0d",
                                         $signed(rsp_payload.sample_out),
                                         $signed(want.sample_out)));
               if (rsp_payload.gain_used !== want.gain_used)
                  note_failure($sformatf("gain_used 0x%04h, expected 0x%04h",
                                         rsp_payload.gain_used, want.gain_used));
               if (rsp_payload.last_out !== want.last_out)
                  note_failure($sformatf("last_out %b, expected %b",
                                         rsp_payload.last_out, want.last_out));
            end
         end
      end
      outstanding <= expected_samples.size();
      mismatch_count <= fail_total;
   end

endmodule

`default_nettype wire

@@ tb/sv/audio_linear_fade_gain_top_test.sv @@
// Top of the linear fade gain testbench: clock, reset, stimulus, register writes and verdict.
`default_nettype none

module audio_linear_fade_gain_top_test;

   import alfg_pkg::*;

   localparam int MAX_CH = 8;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SAMPLES_PER_PHASE = 100;
   localparam int RANDOM_PHASES = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_UNUSED = CSR_CHANNEL_COUNT + 3'd1;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   req_type                     req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   rsp_type                     rsp_payload;
   logic                        csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [CSR_DATA_BITS-1:0]    csr_wdata = '0;

   int mismatches;
   int in_flight;

   int cycle_count = 0;
   int burst_left = 0;
   bit sending = 1'b0;
   int rx_mode = 0;
   int rx_mode_left = 0;
   int rx_hold = 0;

   logic [31:0] cur_start = '0;
   logic [31:0] cur_end = '0;
   int          cur_chans = 1;

   audio_linear_fade_gain_top #(
      .MAX_CHANNELS(MAX_CH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   audio_linear_fade_gain_checker #(
      .MAX_CHANNELS(MAX_CH)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatch_count(mismatches),
      .outstanding(in_flight)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // The receiver switches between always ready, coin-toss readiness and long stalls.
   always @(posedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode <= $urandom_range(0, 2);
         rx_mode_left <= $urandom_range(50, 400);
      end else begin
         rx_mode_left <= rx_mode_left - 1;
      end
      if (rx_hold != 0) begin
         rx_hold <= rx_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            default: begin
               rsp_ready <= 1'b1;
               rx_hold <= $urandom_range(0, 40);
            end
         endcase
      end
   end

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h4000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 31)) - 16'd16;
         default: return 16'($urandom);
      endcase
   endfunction

   // Valid stays high across a burst; gaps are taken only between bursts.
   task automatic send_sample(input logic [15:0] smp, input logic first,
                              input logic [31:0] btime, input logic last);
      req_type item;
      int      gap;
      item.sample_in = smp;
      item.first_of_block = first;
      item.block_time = btime;
      item.last_of_block = last;
      req_payload <= item;
      req_valid <= 1'b1;
      sending = 1'b1;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
         if (gap != 0) begin
            req_valid <= 1'b0;
            sending = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      if (sending) begin
         req_valid <= 1'b0;
         sending = 1'b0;
      end
      do @(posedge clock); while (in_flight != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Unused upper bits of the narrow registers sometimes carry junk, which must be dropped.
   task automatic program_fade(input logic [15:0] gs, input logic [15:0] ge,
                               input logic [31:0] ts, input logic [31:0] te,
                               input logic [3:0] cc);
      write_csr(CSR_GAIN_START, {($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'h0, gs});
      write_csr(CSR_GAIN_END, {($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'h0, ge});
      write_csr(CSR_FADE_START, ts);
      write_csr(CSR_FADE_END, te);
      write_csr(CSR_CHANNEL_COUNT, {($urandom_range(0, 1) == 1) ? 28'($urandom) : 28'h0, cc});
      write_csr(CSR_FIRST_UNUSED + 3'($urandom_range(0, 2)), $urandom);
      csr_we <= 1'b0;
      cur_start = ts;
      cur_end = te;
      cur_chans = (cc == 4'd0) ? 1 : (int'(cc) > MAX_CH) ? MAX_CH : int'(cc);
   endtask

   initial begin
      int          ph;
      int          sent;
      int          n;
      int          k;
      logic [31:0] ts;
      logic [31:0] te;
      logic [31:0] bt;
      logic [31:0] span;
      logic [3:0]  cc;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers at their reset values give zero gain.
      send_sample(16'h7FFF, 1'b1, 32'd5, 1'b0);
      send_sample(16'h8000, 1'b0, $urandom, 1'b1);
      wait_idle();

      // Two channels, ramp from 100 to 200: before, at the start, midway and at the end.
      program_fade(16'h4000, 16'hFFFF, 32'd100, 32'd200, 4'd2);
      send_sample(16'h7FFF, 1'b1, 32'd99, 1'b0);
      send_sample(16'h8000, 1'b0, $urandom, 1'b0);
      send_sample(16'h0001, 1'b0, $urandom, 1'b0);
      send_sample(16'hFFFF, 1'b0, $urandom, 1'b1);
      send_sample(16'd12345, 1'b1, 32'd150, 1'b0);
      send_sample(-16'sd12345, 1'b0, $urandom, 1'b1);
      send_sample(16'h7FFF, 1'b1, 32'd200, 1'b0);
      send_sample(16'h8000, 1'b0, $urandom, 1'b0);
      send_sample(16'h0001, 1'b0, $urandom, 1'b0);
      send_sample(16'h7000, 1'b0, $urandom, 1'b1);
      wait_idle();

      // Equal start and end times, with a channel count of zero.
      program_fade(16'h0000, 16'hFFFF, 32'd1000, 32'd1000, 4'd0);
      send_sample(16'd20000, 1'b1, 32'd999, 1'b0);
      send_sample(-16'sd20000, 1'b0, $urandom, 1'b1);
      wait_idle();

      // End below start, channel count above the maximum.
      program_fade(16'hFFFF, 16'h0000, 32'd500, 32'd300, 4'd15);
      send_sample(-16'sd100, 1'b1, 32'd499, 1'b0);
      send_sample(16'd100, 1'b1, 32'd500, 1'b1);
      wait_idle();

      // The frame time wraps from its top value back to zero.
      program_fade(16'h0064, 16'h00C8, 32'd0, 32'hFFFFFFFF, 4'd1);
      send_sample(16'd30000, 1'b1, 32'hFFFFFFFE, 1'b0);
      send_sample(-16'sd30000, 1'b0, $urandom, 1'b0);
      send_sample(16'd30000, 1'b0, $urandom, 1'b1);
      wait_idle();

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 6))
            0: begin
               ts = $urandom;
               te = $urandom;
            end
            1: begin
               ts = $urandom;
               te = ts;
            end
            2: begin
               ts = 32'h0;
               te = 32'hFFFFFFFF;
            end
            3: begin
               ts = 32'hFFFFFFFF;
               te = 32'hFFFFFFFF;
            end
            default: begin
               ts = $urandom_range(0, 1000);
               te = ts + 32'($urandom_range(1, 40));
            end
         endcase
         cc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, MAX_CH));
         program_fade(pick_gain(), pick_gain(), ts, te, cc);
         span = (cur_end >= cur_start) ? cur_end - cur_start : 32'd0;
         sent = 0;
         while (sent < SAMPLES_PER_PHASE) begin
            if ($urandom_range(0, 4) == 0) begin
               // Stray transactions with arbitrary block marks.
               n = $urandom_range(1, 6);
               repeat (n) send_sample(pick_sample(), 1'($urandom_range(0, 1)), $urandom,
                                      1'($urandom_range(0, 1)));
            end else begin
               // A whole block, mostly starting near or inside the ramp; sometimes run long.
               if ($urandom_range(0, 7) == 0)
                  bt = $urandom;
               else
                  bt = cur_start - 32'($urandom_range(0, 3))
                     + 32'(64'($urandom) % (64'(span) + 64'd4));
               n = $urandom_range(1, 5) * cur_chans;
               if ($urandom_range(0, 7) == 0)
                  n = n + $urandom_range(1, 3);
               for (k = 0; k < n; k++)
                  send_sample(pick_sample(), k == 0, (k == 0) ? bt : $urandom, k == n - 1);
            end
            sent += n;
         end
         wait_idle();
      end

      repeat (60) @(posedge clock);
      if (mismatches == 0 && in_flight == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
